// File: src/swsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-wire sensor frame decoder package
// Shared payload types, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package swsfd_pkg;

    localparam int FREQ_W         = 26;
    localparam int CAPTURE_W      = 16;
    localparam int FRAME_BITS     = 40;
    localparam int BIT_COUNT_W    = 6;
    localparam int CFG_INDEX_W    = 3;
    localparam int TIMER_CLOCK_HZ = 64000000;

    localparam logic [CFG_INDEX_W-1:0] REG_START_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH   = 3'd5;

    typedef struct packed {
        logic [CAPTURE_W-1:0] capture;
        logic                 frame_end;
    } in_t;

    typedef struct packed {
        logic               ok;
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } out_t;

endpackage

// File: src/single_wire_sensor_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-wire sensor frame decoder
// Turns timer capture stamps into humidity and temperature readings.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel carries one capture stamp and a
// frame_end flag. Every stamp after the first of a frame forms a pulse whose
// frequency is found by a bit-serial restoring divider, one quotient bit per
// cycle. The pulse is then matched against the start, one and zero windows
// set through the configuration port, which may only be written while idle.
// A stamp that forms a pulse is loaded, goes through 26 divider steps and
// is classified before the next stamp can be taken. The first stamp of a
// frame is only recorded, and a stamp with frame_end set also passes
// through the emit state. The stamp with frame_end set produces one result
// transfer, loaded into the output register from the emit state once that
// register is free. The result sits in an output register; while the
// receiver stalls it holds, and a further frame_end waits for it to drain.
// Input stall is high while a stamp is being worked on.
// Reset clears the frame state, the result valid flag and all window
// registers to zero.
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_decoder_unit #(
    parameter int TIMER_CLOCK_HZ = swsfd_pkg::TIMER_CLOCK_HZ
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [swsfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [swsfd_pkg::FREQ_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  swsfd_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output swsfd_pkg::out_t                     out_data
);

    localparam int FW     = swsfd_pkg::FREQ_W;
    localparam int CW     = swsfd_pkg::CAPTURE_W;
    localparam int NB     = swsfd_pkg::FRAME_BITS;
    localparam int BCW    = swsfd_pkg::BIT_COUNT_W;
    localparam int STEP_W = $clog2(FW);

    localparam logic [FW-1:0]     CLOCK_HZ  = FW'(TIMER_CLOCK_HZ);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FW - 1);
    localparam logic [BCW-1:0]    BITS_FULL = BCW'(NB);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_CLASS = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [FW-1:0] start_low_reg, start_high_reg;
    logic [FW-1:0] zero_low_reg, zero_high_reg;
    logic [FW-1:0] one_low_reg, one_high_reg;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic              start_seen_reg, start_seen_next;
    logic [BCW-1:0]    bit_count_reg, bit_count_next;
    logic [NB-1:0]     frame_bits_reg, frame_bits_next;
    logic              last_reg, last_next;
    logic [CW-1:0]     delta_reg, delta_next;
    logic [FW-1:0]     num_reg, num_next;
    logic [CW:0]       rem_reg, rem_next;
    logic [FW-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    swsfd_pkg::out_t   out_data_reg, out_data_next;

    logic          accept;
    logic          out_free;
    logic [CW:0]   trial;
    logic          fits;
    logic [FW-1:0] freq;
    logic          in_start, in_one, in_zero;
    logic [7:0]    b0, b1, b2, b3, b4;
    logic [7:0]    sum;
    logic          frame_ok;
    logic [15:0]   traw;
    logic [15:0]   temp;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign trial = {rem_reg[CW-1:0], num_reg[FW-1]};
    assign fits  = (trial >= {1'b0, delta_reg});
    assign freq  = (delta_reg == '0) ? '0 : quo_reg;

    assign in_start = (start_low_reg < freq) && (freq < start_high_reg);
    assign in_one   = (one_low_reg < freq) && (freq < one_high_reg);
    assign in_zero  = (zero_low_reg < freq) && (freq < zero_high_reg);

    assign b0       = frame_bits_reg[39:32];
    assign b1       = frame_bits_reg[31:24];
    assign b2       = frame_bits_reg[23:16];
    assign b3       = frame_bits_reg[15:8];
    assign b4       = frame_bits_reg[7:0];
    assign sum      = b0 + b1 + b2 + b3;
    assign frame_ok = (bit_count_reg == BITS_FULL) && (sum == b4);
    assign traw     = {b2, b3};
    assign temp     = traw[15] ? (16'd0 - {1'b0, traw[14:0]}) : traw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg  <= '0;
            start_high_reg <= '0;
            zero_low_reg   <= '0;
            zero_high_reg  <= '0;
            one_low_reg    <= '0;
            one_high_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                swsfd_pkg::REG_START_LOW:  start_low_reg  <= cfg_data;
                swsfd_pkg::REG_START_HIGH: start_high_reg <= cfg_data;
                swsfd_pkg::REG_ZERO_LOW:   zero_low_reg   <= cfg_data;
                swsfd_pkg::REG_ZERO_HIGH:  zero_high_reg  <= cfg_data;
                swsfd_pkg::REG_ONE_LOW:    one_low_reg    <= cfg_data;
                swsfd_pkg::REG_ONE_HIGH:   one_high_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        start_seen_next = start_seen_reg;
        bit_count_next  = bit_count_reg;
        frame_bits_next = frame_bits_reg;
        last_next       = last_reg;
        delta_next      = delta_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    delta_next     = in_data.capture - prev_reg;
                    prev_next      = in_data.capture;
                    have_prev_next = 1'b1;
                    last_next      = in_data.frame_end;
                    num_next       = CLOCK_HZ;
                    rem_next       = '0;
                    quo_next       = '0;
                    step_next      = '0;
                    if (have_prev_reg)
                    begin
                        state_next = S_DIV;
                    end
                    else if (in_data.frame_end)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIV:
            begin
                num_next = {num_reg[FW-2:0], 1'b0};
                rem_next = fits ? (trial - {1'b0, delta_reg}) : trial;
                quo_next = {quo_reg[FW-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (!start_seen_reg)
                begin
                    start_seen_next = in_start;
                end
                else if (bit_count_reg < BITS_FULL && (in_one || in_zero))
                begin
                    frame_bits_next = {frame_bits_reg[NB-2:0], in_one};
                    bit_count_next  = bit_count_reg + 1'b1;
                end
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                   = 1'b1;
                    out_data_next.ok                 = frame_ok;
                    out_data_next.humidity_tenths    = frame_ok ? {b0, b1} : 16'd0;
                    out_data_next.temperature_tenths = frame_ok ? temp : 16'd0;
                    prev_next       = '0;
                    have_prev_next  = 1'b0;
                    start_seen_next = 1'b0;
                    bit_count_next  = '0;
                    frame_bits_next = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_reg       <= '0;
            have_prev_reg  <= 1'b0;
            start_seen_reg <= 1'b0;
            bit_count_reg  <= '0;
            frame_bits_reg <= '0;
            last_reg       <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            have_prev_reg  <= have_prev_next;
            start_seen_reg <= start_seen_next;
            bit_count_reg  <= bit_count_next;
            frame_bits_reg <= frame_bits_next;
            last_reg       <= last_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg    <= delta_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

    // The bit counter never passes the frame length.
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= BITS_FULL)
        else $error("bit counter beyond frame length");

    // Bits are only collected once the start pulse has been seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bit_count_reg != '0) |-> start_seen_reg)
        else $error("bits collected before start pulse");

    // A failed frame reports zero readings.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.ok) |->
            (out_data.humidity_tenths == 16'd0 && out_data.temperature_tenths == 16'sd0))
        else $error("failed frame with nonzero readings");

    // Leaving the emit state always loads a fresh result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && state_next == S_IDLE) |=> out_valid_reg)
        else $error("frame end without result");

    // After its last step the divider hands over to classification.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == LAST_STEP) |=> (state_reg == S_CLASS))
        else $error("divider did not hand over to classification");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-wire sensor frame decoder testbench
// Sends capture stamps that form start pulses, bit pulses, malformed frames
// and noise, under several window settings. Every transfer is predicted by a
// local copy of the decoder, and each result transfer is checked against the
// oldest predicted reading. Both channels idle at random, and the receiver
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb;

    localparam int FREQ_W         = swsfd_pkg::FREQ_W;
    localparam int CFG_INDEX_W    = swsfd_pkg::CFG_INDEX_W;
    localparam int FRAME_BITS     = swsfd_pkg::FRAME_BITS;
    localparam int TIMER_CLOCK_HZ = swsfd_pkg::TIMER_CLOCK_HZ;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 3000;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum logic [2:0] {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_SHORT,
        FRAME_LONG,
        FRAME_NOISE
    } frame_kind_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [FREQ_W-1:0]      cfg_data;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    swsfd_pkg::in_t         in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    swsfd_pkg::out_t        out_data;

    swsfd_pkg::in_t  pending_stamps[$];
    swsfd_pkg::out_t expected_readings[$];
    int   stamps_queued = 0;
    int   fail_count = 0;
    int   stuck_cycles = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic hold_go = 1'b0;
    logic hold_used = 1'b0;
    logic steady = 1'b0;
    logic stamp_taken = 1'b0;

    // Window registers and frame state of the local decoder copy.
    logic [FREQ_W-1:0] win [6];
    logic [15:0]       prev_capture = '0;
    logic              have_prev = 1'b0;
    logic              start_seen = 1'b0;
    int                bit_count = 0;
    logic [39:0]       frame_bits = '0;

    // Nominal pulse lengths in timer counts used to build frames.
    int nom_start  = 10240;
    int nom_zero   = 1700;
    int nom_one    = 4500;
    int nom_margin = 300;

    single_wire_sensor_frame_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic in_win(input logic [FREQ_W-1:0] freq,
                                    input logic [FREQ_W-1:0] lo,
                                    input logic [FREQ_W-1:0] hi);
        return (lo < freq) && (freq < hi);
    endfunction

    function automatic logic decode_stamp(input swsfd_pkg::in_t item,
                                          output swsfd_pkg::out_t reading);
        logic [15:0]       delta;
        logic [FREQ_W-1:0] freq;
        logic [7:0]        checksum;
        logic [15:0]       traw;
        reading = '0;
        if (have_prev)
        begin
            delta = item.capture - prev_capture;
            freq = (delta == 16'd0) ? '0 : FREQ_W'(32'(TIMER_CLOCK_HZ) / 32'(delta));
            if (!start_seen)
            begin
                if (in_win(freq, win[swsfd_pkg::REG_START_LOW],
                           win[swsfd_pkg::REG_START_HIGH]))
                    start_seen = 1'b1;
            end
            else if (bit_count < FRAME_BITS)
            begin
                if (in_win(freq, win[swsfd_pkg::REG_ONE_LOW], win[swsfd_pkg::REG_ONE_HIGH]))
                begin
                    frame_bits = {frame_bits[38:0], 1'b1};
                    bit_count++;
                end
                else if (in_win(freq, win[swsfd_pkg::REG_ZERO_LOW],
                                win[swsfd_pkg::REG_ZERO_HIGH]))
                begin
                    frame_bits = {frame_bits[38:0], 1'b0};
                    bit_count++;
                end
            end
        end
        prev_capture = item.capture;
        have_prev = 1'b1;
        if (!item.frame_end)
            return 1'b0;
        checksum = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16]
                 + frame_bits[15:8];
        if (bit_count == FRAME_BITS && checksum == frame_bits[7:0])
        begin
            traw = frame_bits[23:8];
            reading.ok = 1'b1;
            reading.humidity_tenths = frame_bits[39:24];
            reading.temperature_tenths = traw[15] ? (16'd0 - {1'b0, traw[14:0]}) : traw;
        end
        prev_capture = '0;
        have_prev = 1'b0;
        start_seen = 1'b0;
        bit_count = 0;
        frame_bits = '0;
        return 1'b1;
    endfunction

    // Decoder prediction and result checking.
    always @(posedge clk)
    begin : decode_monitor
        swsfd_pkg::out_t want;
        stamp_taken <= in_valid && !in_stall;
        if (out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected result transfer: ok %0d, humidity %0d, temperature %0d",
                       out_data.ok, out_data.humidity_tenths, out_data.temperature_tenths);
                fail_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (out_data.ok !== want.ok)
                begin
                    $error("ok mismatch: expected %0d, actual %0d", want.ok, out_data.ok);
                    fail_count++;
                end
                if (out_data.humidity_tenths !== want.humidity_tenths)
                begin
                    $error("humidity_tenths mismatch: expected %0d, actual %0d",
                           want.humidity_tenths, out_data.humidity_tenths);
                    fail_count++;
                end
                if (out_data.temperature_tenths !== want.temperature_tenths)
                begin
                    $error("temperature_tenths mismatch: expected %0d, actual %0d",
                           want.temperature_tenths, out_data.temperature_tenths);
                    fail_count++;
                end
            end
        end
        if (in_valid && !in_stall)
        begin
            if (decode_stamp(in_data, want))
                expected_readings.push_back(want);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin : stamp_driver
        logic           next_valid;
        swsfd_pkg::in_t next_data;
        next_valid = in_valid;
        next_data = in_data;
        if (in_valid && stamp_taken)
            next_valid = 1'b0;
        if (!next_valid)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_stamps.size() > 0)
            begin
                next_data = pending_stamps.pop_front();
                next_valid = 1'b1;
                if (!steady && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 15);
            end
        end
        in_valid <= next_valid;
        in_data <= next_data;
    end

    always @(negedge clk)
    begin : result_sink
        if (hold_go && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!steady && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 15);
        end
    end

    task automatic queue_stamp(input logic [15:0] capture, input logic last);
        swsfd_pkg::in_t item;
        item.capture = capture;
        item.frame_end = last;
        pending_stamps.push_back(item);
        stamps_queued++;
    endtask

    function automatic logic [15:0] pulse_delta(input int nominal);
        return 16'(nominal - nom_margin + int'($urandom_range(0, 2 * nom_margin)));
    endfunction

    task automatic make_frame(input frame_kind_t kind, input logic neg_zero);
        logic [15:0] stamp;
        logic [15:0] hum;
        logic [15:0] temp;
        logic [7:0]  sum;
        logic [39:0] payload;
        logic        one_bit;
        int          nbits;
        int          extra;
        int          i;
        stamp = 16'($urandom);
        if (kind == FRAME_NOISE)
        begin
            extra = $urandom_range(0, 7);
            queue_stamp(stamp, extra == 0);
            for (i = 0; i < extra; i++)
                queue_stamp(16'($urandom), i == extra - 1);
            return;
        end
        case ($urandom_range(0, 3))
            0: hum = 16'h0000;
            1: hum = 16'hFFFF;
            default: hum = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: temp = 16'h8000;
            1: temp = 16'hFFFF;
            2: temp = 16'h7FFF;
            3: temp = 16'h0000;
            default: temp = 16'($urandom);
        endcase
        if (neg_zero)
            temp = 16'h8000;
        sum = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];
        if (kind == FRAME_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        payload = {hum, temp, sum};
        nbits = 40;
        if (kind == FRAME_SHORT)
            nbits = $urandom_range(0, 39);
        else if (kind == FRAME_LONG)
            nbits = $urandom_range(41, 45);
        queue_stamp(stamp, 1'b0);
        if ($urandom_range(0, 3) == 0)
        begin
            stamp = stamp + 16'($urandom);
            queue_stamp(stamp, 1'b0);
        end
        stamp = stamp + pulse_delta(nom_start);
        queue_stamp(stamp, nbits == 0);
        for (i = 0; i < nbits; i++)
        begin
            if (kind == FRAME_LONG && $urandom_range(0, 9) == 0)
            begin
                stamp = stamp + 16'($urandom);
                queue_stamp(stamp, 1'b0);
            end
            one_bit = (i < 40) ? payload[39 - i] : 1'($urandom_range(0, 1));
            stamp = stamp + pulse_delta(one_bit ? nom_one : nom_zero);
            queue_stamp(stamp, i == nbits - 1);
        end
    endtask

    task automatic random_frames(input int count);
        int target;
        target = stamps_queued + count;
        while (stamps_queued < target)
        begin
            case ($urandom_range(0, 9))
                6: make_frame(FRAME_BAD_SUM, 1'b0);
                7: make_frame(FRAME_SHORT, 1'b0);
                8: make_frame(FRAME_LONG, 1'b0);
                9: make_frame(FRAME_NOISE, 1'b0);
                default: make_frame(FRAME_GOOD, 1'b0);
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [FREQ_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index <= swsfd_pkg::REG_ONE_HIGH)
            win[index] = value;
    endtask

    task automatic apply_windows(input logic [FREQ_W-1:0] s_lo, input logic [FREQ_W-1:0] s_hi,
                                 input logic [FREQ_W-1:0] z_lo, input logic [FREQ_W-1:0] z_hi,
                                 input logic [FREQ_W-1:0] o_lo, input logic [FREQ_W-1:0] o_hi);
        write_reg(swsfd_pkg::REG_START_LOW, s_lo);
        write_reg(swsfd_pkg::REG_START_HIGH, s_hi);
        write_reg(swsfd_pkg::REG_ZERO_LOW, z_lo);
        write_reg(swsfd_pkg::REG_ZERO_HIGH, z_hi);
        write_reg(swsfd_pkg::REG_ONE_LOW, o_lo);
        write_reg(swsfd_pkg::REG_ONE_HIGH, o_hi);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [FREQ_W-1:0] win_low(input int nominal, input int margin);
        return FREQ_W'(TIMER_CLOCK_HZ / (nominal + margin) - 1);
    endfunction

    function automatic logic [FREQ_W-1:0] win_high(input int nominal, input int margin);
        return FREQ_W'(TIMER_CLOCK_HZ / (nominal - margin) + 1);
    endfunction

    task automatic use_timing(input int start_len, input int zero_len,
                              input int one_len, input int margin);
        nom_start = start_len;
        nom_zero = zero_len;
        nom_one = one_len;
        nom_margin = margin;
        apply_windows(win_low(start_len, margin), win_high(start_len, margin),
                      win_low(zero_len, margin), win_high(zero_len, margin),
                      win_low(one_len, margin), win_high(one_len, margin));
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_stamps.size() != 0 || in_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (win[i])
            win[i] = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Windows at reset: nothing matches, a lone stamp ends a frame.
        queue_stamp(16'h1234, 1'b1);
        queue_stamp(16'h0000, 1'b0);
        queue_stamp(16'hFFFF, 1'b0);
        queue_stamp(16'hFFFF, 1'b1);
        wait_idle();

        // Spare indexes are ignored; then fully open windows.
        write_reg(REG_SPARE_A, FREQ_MAX);
        write_reg(REG_SPARE_B, FREQ_MAX);
        apply_windows('0, FREQ_MAX, '0, FREQ_MAX, '0, FREQ_MAX);
        queue_stamp(16'h0000, 1'b0);
        queue_stamp(16'h0001, 1'b0);
        queue_stamp(16'h0001, 1'b0);
        queue_stamp(16'h0000, 1'b0);
        queue_stamp(16'hFFFF, 1'b1);
        wait_idle();

        use_timing(10240, 1700, 4500, 300);
        hold_go = 1'b1;
        make_frame(FRAME_GOOD, 1'b1);
        make_frame(FRAME_LONG, 1'b0);
        random_frames(520);
        wait_idle();

        use_timing(20000, 2500, 6000, 400);
        random_frames(500);
        wait_idle();

        apply_windows('0, FREQ_MAX, '0, FREQ_MAX, '0, FREQ_MAX);
        random_frames(200);
        wait_idle();

        apply_windows(FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX);
        random_frames(100);
        wait_idle();

        steady = 1'b1;
        use_timing(10240, 1700, 4500, 300);
        random_frames(300);
        wait_idle();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
